### rtl/mcr_pkg.sv
// shared types, field layout and constants of the midpoint circle rasteriser
`timescale 1ns / 1ps
package mcr_pkg;

  // field widths
  localparam int COORD_BITS     = 16;
  localparam int WALK_BITS      = 12;
  localparam int DEC_BITS       = 16;
  localparam int RADIUS_BITS    = 11;
  localparam int COLOR_BITS     = 16;
  localparam int DIM_BITS       = 12;
  localparam int PITCH_BITS     = 13;
  localparam int ADDR_BITS      = 24;
  localparam int CFG_DATA_BITS  = 13;
  localparam int CFG_INDEX_BITS = 2;

  // eight mirrored points per step
  localparam int POINTS         = 8;
  localparam int POINT_IDX_BITS = $clog2(POINTS);

  // input item layout
  localparam int IN_CX_LSB      = 0;
  localparam int IN_CY_LSB      = IN_CX_LSB + COORD_BITS;
  localparam int IN_RADIUS_LSB  = IN_CY_LSB + COORD_BITS;
  localparam int IN_COLOR_LSB   = IN_RADIUS_LSB + RADIUS_BITS;
  localparam int IN_USED_BITS   = IN_COLOR_LSB + COLOR_BITS;
  localparam int IN_TDATA_BITS  = ((IN_USED_BITS + 7) / 8) * 8;

  // result item layout
  localparam int OUT_PX_LSB     = 0;
  localparam int OUT_PY_LSB     = OUT_PX_LSB + COORD_BITS;
  localparam int OUT_ADDR_LSB   = OUT_PY_LSB + COORD_BITS;
  localparam int OUT_COLOR_LSB  = OUT_ADDR_LSB + ADDR_BITS;
  localparam int OUT_TDATA_BITS = OUT_COLOR_LSB + COLOR_BITS;
  localparam int OUT_WE_BIT     = 0;
  localparam int OUT_DONE_BIT   = 1;
  localparam int OUT_TUSER_BITS = 2;

  // register reset values
  localparam logic [DIM_BITS-1:0]   WIDTH_RESET  = DIM_BITS'(640);
  localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = DIM_BITS'(480);
  localparam logic [PITCH_BITS-1:0] PITCH_RESET  = PITCH_BITS'(640);

  // decision term constants
  localparam logic [DEC_BITS-1:0] DEC_INIT     = DEC_BITS'(3);
  localparam logic [DEC_BITS-1:0] DEC_INC_KEEP = DEC_BITS'(6);
  localparam logic [DEC_BITS-1:0] DEC_INC_DIAG = DEC_BITS'(10);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_ROW_PITCH     = 2'd2
  } cfg_index_t;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  // snapshot of one step, held while its eight points go out
  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [WALK_BITS-1:0]  x;
    logic [WALK_BITS-1:0]  y;
    logic [COLOR_BITS-1:0] color;
    logic                  done;
  } step_job_t;

endpackage

### rtl/midpoint_circle_rasterizer_unit.sv
// A step item's snapshot is registered in the point sequencer, and each of its points in the output register.
// The sequencer gives one point per cycle while out_tready does not stall the output, eight per step item;
// a start item, or a step while idle, is taken but gives no point.
// The next step item is taken in the cycle its predecessor's eighth point is loaded.
// Reset (synchronous, active low) clears the walk to idle and loads 640 x 480, pitch 640.
`timescale 1ns / 1ps
module midpoint_circle_rasterizer_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // center_x, center_y, radius, color, zero padding
  input  logic [mcr_pkg::IN_TDATA_BITS-1:0]    in_tdata,
  // command
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // pixel_x, pixel_y, word_address, pixel_color
  output logic [mcr_pkg::OUT_TDATA_BITS-1:0]   out_tdata,
  // write_enable, circle_done
  output logic [mcr_pkg::OUT_TUSER_BITS-1:0]   out_tuser,
  output logic                                 out_tlast,
  input  logic                                 cfg_we,
  input  logic [mcr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [mcr_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import mcr_pkg::*;

  // configuration registers
  logic [DIM_BITS-1:0]   width_r;
  logic [DIM_BITS-1:0]   height_r;
  logic [PITCH_BITS-1:0] pitch_r;

  // walk state
  logic [WALK_BITS-1:0]  walk_x_r, walk_x_nxt;
  logic [WALK_BITS-1:0]  walk_y_r, walk_y_nxt;
  logic [DEC_BITS-1:0]   dec_r, dec_nxt;
  logic [COORD_BITS-1:0] center_col_r;
  logic [COORD_BITS-1:0] center_row_r;
  logic [COLOR_BITS-1:0] color_r;
  logic                  active_r, active_nxt;

  // point sequencer
  step_job_t                 job_r;
  logic                      job_valid_r;
  logic [POINT_IDX_BITS-1:0] idx_r;

  // output register
  logic                      out_valid_r;
  logic [OUT_TDATA_BITS-1:0] out_data_r;
  logic [OUT_TUSER_BITS-1:0] out_user_r;
  logic                      out_last_r;

  // input fields
  cmd_t                   in_cmd;
  logic [COORD_BITS-1:0]  in_cx;
  logic [COORD_BITS-1:0]  in_cy;
  logic [RADIUS_BITS-1:0] in_radius;
  logic [COLOR_BITS-1:0]  in_color;

  logic in_fire, start_fire, step_fire, out_load, last_pt;

  // step update terms
  logic [DEC_BITS-1:0]     x_w, y_w;
  logic                    dec_pos;
  logic signed [WALK_BITS+1:0] x_next_s, y_next_s;

  // point terms
  logic [WALK_BITS-1:0]  da, db;
  logic [COORD_BITS-1:0] da_w, db_w, px, py;
  logic                  pt_we;
  logic [DIM_BITS+PITCH_BITS-1:0] addr_sum;
  logic [ADDR_BITS-1:0]  pt_addr;

  assign in_cmd    = cmd_t'(in_tuser);
  assign in_cx     = in_tdata[IN_CX_LSB +: COORD_BITS];
  assign in_cy     = in_tdata[IN_CY_LSB +: COORD_BITS];
  assign in_radius = in_tdata[IN_RADIUS_LSB +: RADIUS_BITS];
  assign in_color  = in_tdata[IN_COLOR_LSB +: COLOR_BITS];

  // handshake
  assign out_load   = job_valid_r && (!out_valid_r || out_tready);
  assign last_pt    = (idx_r == POINT_IDX_BITS'(POINTS - 1));
  assign in_tready  = !job_valid_r || (out_load && last_pt);
  assign in_fire    = in_tvalid && in_tready;
  assign start_fire = in_fire && (in_cmd == CMD_START);
  assign step_fire  = in_fire && (in_cmd == CMD_STEP) && active_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      pitch_r  <= PITCH_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_SCREEN_WIDTH:  width_r  <= cfg_data[DIM_BITS-1:0];
        CFG_SCREEN_HEIGHT: height_r <= cfg_data[DIM_BITS-1:0];
        CFG_ROW_PITCH:     pitch_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // midpoint update of decision term and walk position
  always_comb begin
    x_w      = DEC_BITS'(walk_x_r);
    y_w      = DEC_BITS'(walk_y_r);
    dec_pos  = !dec_r[DEC_BITS-1] && (|dec_r);
    x_next_s = signed'({2'b00, walk_x_r}) + 14'sd1;
    if (dec_pos) begin
      dec_nxt  = dec_r + ((x_w - y_w) << 2) + DEC_INC_DIAG;
      y_next_s = signed'({2'b00, walk_y_r}) - 14'sd1;
    end else begin
      dec_nxt  = dec_r + (x_w << 2) + DEC_INC_KEEP;
      y_next_s = signed'({2'b00, walk_y_r});
    end
    walk_x_nxt = x_next_s[WALK_BITS-1:0];
    walk_y_nxt = y_next_s[WALK_BITS-1:0];
    active_nxt = !(x_next_s > y_next_s);
  end

  // walk state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_x_r     <= '0;
      walk_y_r     <= '0;
      dec_r        <= '0;
      center_col_r <= '0;
      center_row_r <= '0;
      color_r      <= '0;
      active_r     <= 1'b0;
    end else if (start_fire) begin
      walk_x_r     <= '0;
      walk_y_r     <= WALK_BITS'(in_radius);
      dec_r        <= DEC_INIT - DEC_BITS'({in_radius, 1'b0});
      center_col_r <= in_cx;
      center_row_r <= in_cy;
      color_r      <= in_color;
      active_r     <= 1'b1;
    end else if (step_fire) begin
      walk_x_r <= walk_x_nxt;
      walk_y_r <= walk_y_nxt;
      dec_r    <= dec_nxt;
      active_r <= active_nxt;
    end
  end

  // step snapshot for the sequencer
  always_ff @(posedge clk) begin
    if (step_fire) begin
      job_r.cx    <= center_col_r;
      job_r.cy    <= center_row_r;
      job_r.x     <= walk_x_r;
      job_r.y     <= walk_y_r;
      job_r.color <= color_r;
      job_r.done  <= !active_nxt;
    end
  end

  // point sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (out_load) begin
        idx_r <= idx_r + POINT_IDX_BITS'(1);
      end
      if (step_fire) begin
        job_valid_r <= 1'b1;
      end else if (out_load && last_pt) begin
        job_valid_r <= 1'b0;
      end
    end
  end

  // octant point: bit 2 swaps x and y, bit 0 negates the column offset, bit 1 the row offset
  always_comb begin
    da       = idx_r[2] ? job_r.y : job_r.x;
    db       = idx_r[2] ? job_r.x : job_r.y;
    da_w     = COORD_BITS'(da);
    db_w     = COORD_BITS'(db);
    px       = idx_r[0] ? (job_r.cx - da_w) : (job_r.cx + da_w);
    py       = idx_r[1] ? (job_r.cy - db_w) : (job_r.cy + db_w);
    pt_we    = !px[COORD_BITS-1] && !py[COORD_BITS-1] &&
               (px < COORD_BITS'(width_r)) && (py < COORD_BITS'(height_r));
    addr_sum = (py[DIM_BITS-1:0] * pitch_r) + (DIM_BITS+PITCH_BITS)'(px[DIM_BITS-1:0]);
    pt_addr  = pt_we ? addr_sum[ADDR_BITS-1:0] : '0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {job_r.color, pt_addr, py, px};
      out_user_r <= {job_r.done && last_pt, pt_we};
      out_last_r <= last_pt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

### rtl/mcr_checker.sv
// port-level checks for the midpoint circle rasteriser, bound to the top level
`timescale 1ns / 1ps
module mcr_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [mcr_pkg::OUT_TDATA_BITS-1:0]  out_tdata,
  input logic [mcr_pkg::OUT_TUSER_BITS-1:0]  out_tuser,
  input logic                                out_tlast
);
  import mcr_pkg::*;

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result item changed while stalled");

  // end of circle only on the closing point of a step
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[OUT_DONE_BIT] |-> out_tlast)
    else $error("circle_done without last_of_step");

  // off-screen points carry a zero address
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[OUT_WE_BIT] |-> out_tdata[OUT_ADDR_LSB +: ADDR_BITS] == '0)
    else $error("address set on a masked point");

  // enabled points lie in the positive quadrant
  a_we_positive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[OUT_WE_BIT] |->
      !out_tdata[OUT_PX_LSB + COORD_BITS - 1] && !out_tdata[OUT_PY_LSB + COORD_BITS - 1])
    else $error("write enabled on a negative coordinate");

endmodule

bind midpoint_circle_rasterizer_unit mcr_checker u_mcr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
